// File: rtl/core/srnce_pkg.sv
`default_nettype none

package srnce_pkg;

  localparam int unsigned ScratchBytes = 32;
  localparam int unsigned ScratchIdxW = $clog2(ScratchBytes);

  // Offset value that marks a full scratchpad.
  localparam logic [ScratchIdxW:0] ScratchFull = (ScratchIdxW + 1)'(ScratchBytes);
  localparam logic [ScratchIdxW-1:0] ScratchLast = ScratchIdxW'(ScratchBytes - 1);

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdWriteSp = 8'h0F;
  localparam logic [7:0] CmdCopySp  = 8'h55;
  localparam logic [7:0] CmdReadMem = 8'hF0;

  localparam logic [15:0] AddrStoreEnd   = 16'h0200;
  localparam logic [15:0] AddrClockFirst = 16'h0202;
  localparam logic [15:0] AddrClockLast  = 16'h0206;

  localparam int unsigned ClockBytes = 5;

  typedef enum logic [2:0] {
    KindOneWireReset   = 3'd0,
    KindThreeWireReset = 3'd1,
    KindWrite          = 3'd2,
    KindRead           = 3'd3,
    KindClockPulse     = 3'd4,
    KindTick           = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    StepIdle    = 4'd0,
    StepCommand = 4'd1,
    StepAddrLo  = 4'd2,
    StepAddrHi  = 4'd3,
    StepEndOfs  = 4'd4,
    StepStart   = 4'd5,
    StepReadMem = 4'd6,
    StepWriteSp = 4'd7,
    StepCopySp  = 4'd8
  } step_e;

  typedef struct packed {
    logic step;
    logic clear;
    logic copy;
    logic capture;
  } ctl_cmd_t;

  typedef struct packed {
    logic copy_start;
    logic copy_last;
    logic clear_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/srnce_dp.sv
`default_nettype none

module srnce_dp import srnce_pkg::*; #(
  parameter int unsigned STORE_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctl_cmd_t   cmd_i,
  input  wire logic [2:0] kind_i,
  input  wire logic [7:0] write_data_i,
  output dp_stat_t        stat_o,
  output logic [7:0]      read_data_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    SrcZero  = 2'd0,
    SrcStore = 2'd1,
    SrcClock = 2'd2
  } src_e;

  kind_e kind;
  step_e list_q [8];
  step_e list_d [8];
  step_e cur;
  logic [2:0] ptr_q, ptr_d;
  logic [7:0] alo_q, alo_d, ahi_q, ahi_d;
  logic [ScratchIdxW-1:0] end_q, end_d;
  logic [ScratchIdxW:0] off_q, off_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] base;
  logic [ScratchIdxW-1:0] copy_idx_q, copy_idx_d;
  logic copy_start;
  logic sp_we;
  logic [7:0] scratch_q [ScratchBytes];
  logic [ClockBytes-1:0][7:0] clock_q, clock_d;
  logic [2:0] byte_off;
  logic [7:0] clk_byte;
  logic [7:0] clk_byte_q;
  logic in_store, in_clock;
  logic [AW-1:0] clr_idx_q;
  logic [7:0] store_mem [STORE_BYTES];
  logic [7:0] store_rd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0] mem_wd;
  logic [7:0] copy_byte;
  logic rd_en;
  src_e src_q, src_d;
  logic [7:0] read_data_q;

  assign kind = kind_e'(kind_i);
  assign cur = list_q[ptr_q];
  assign copy_byte = scratch_q[copy_idx_q];

  assign in_store = ({16'd0, addr_q} < 32'(STORE_BYTES)) && (addr_q < AddrStoreEnd);
  assign in_clock = (addr_q >= AddrClockFirst) && (addr_q <= AddrClockLast);
  assign byte_off = addr_q[2:0] - AddrClockFirst[2:0];

  // Command sequencer: one step per transfer, plus the address walk of a copy.
  always_comb begin
    list_d     = list_q;
    ptr_d      = ptr_q;
    alo_d      = alo_q;
    ahi_d      = ahi_q;
    end_d      = end_q;
    off_d      = off_q;
    addr_d     = addr_q;
    copy_idx_d = copy_idx_q;
    copy_start = 1'b0;
    sp_we      = 1'b0;
    base       = '0;
    if (cmd_i.step) begin
      unique case (kind)
        KindOneWireReset: begin
          list_d[0] = StepIdle;
          ptr_d     = 3'd0;
        end
        KindThreeWireReset: begin
          list_d[0] = StepCommand;
          ptr_d     = 3'd0;
        end
        KindWrite: begin
          unique case (cur)
            StepIdle: begin
              if (write_data_i == CmdSkipRom) begin
                list_d[0] = StepCommand;
                ptr_d     = 3'd0;
              end
            end
            StepCommand: begin
              if (write_data_i == CmdWriteSp) begin
                list_d[0] = StepAddrLo;
                list_d[1] = StepAddrHi;
                list_d[2] = StepStart;
                list_d[3] = StepWriteSp;
                ptr_d     = 3'd0;
              end else if (write_data_i == CmdCopySp) begin
                list_d[0] = StepAddrLo;
                list_d[1] = StepAddrHi;
                list_d[2] = StepEndOfs;
                list_d[3] = StepStart;
                list_d[4] = StepCopySp;
                ptr_d     = 3'd0;
              end else if (write_data_i == CmdReadMem) begin
                list_d[0] = StepAddrLo;
                list_d[1] = StepAddrHi;
                list_d[2] = StepStart;
                list_d[3] = StepReadMem;
                ptr_d     = 3'd0;
              end
            end
            StepAddrLo: begin
              alo_d = write_data_i;
              ptr_d = ptr_q + 3'd1;
            end
            StepAddrHi: begin
              ahi_d = write_data_i;
              ptr_d = ptr_q + 3'd1;
            end
            StepEndOfs: begin
              end_d = (write_data_i > 8'(ScratchLast)) ? ScratchLast
                                                      : write_data_i[ScratchIdxW-1:0];
              ptr_d = ptr_q + 3'd1;
            end
            StepWriteSp: begin
              if (off_q < ScratchFull) begin
                sp_we = 1'b1;
                off_d = off_q + 1'b1;
              end
            end
            default: ;
          endcase
          if (list_d[ptr_d] == StepStart) begin
            base = {ahi_d, alo_d};
            unique case (list_d[3'(ptr_d + 3'd1)])
              StepReadMem: addr_d = base - 16'd1;
              StepWriteSp: begin
                addr_d = base;
                off_d  = {1'b0, base[ScratchIdxW-1:0]};
              end
              StepCopySp: begin
                addr_d     = base;
                copy_idx_d = '0;
                copy_start = 1'b1;
              end
              default: ;
            endcase
            ptr_d = ptr_d + 3'd1;
          end
        end
        KindClockPulse: begin
          if (cur == StepReadMem) begin
            addr_d = addr_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.copy) begin
      addr_d     = addr_q + 16'd1;
      copy_idx_d = copy_idx_q + 1'b1;
    end
  end

  always_comb begin
    clock_d = clock_q;
    if (cmd_i.step && (kind == KindTick)) begin
      clock_d = clock_q + 40'd1;
    end
    for (int b = 0; b < ClockBytes; b++) begin
      if (cmd_i.copy && in_clock && (byte_off == 3'(b))) begin
        clock_d[b] = copy_byte;
      end
    end
  end

  always_comb begin
    clk_byte = '0;
    for (int b = 0; b < ClockBytes; b++) begin
      if (byte_off == 3'(b)) begin
        clk_byte = clock_q[b];
      end
    end
  end

  assign rd_en = cmd_i.step && (kind == KindRead) && (cur == StepReadMem);

  always_comb begin
    src_d = src_q;
    if (cmd_i.step) begin
      src_d = SrcZero;
      if (rd_en && in_store) begin
        src_d = SrcStore;
      end else if (rd_en && in_clock) begin
        src_d = SrcClock;
      end
    end
  end

  assign mem_we = cmd_i.clear || (cmd_i.copy && in_store);
  assign mem_wa = cmd_i.clear ? clr_idx_q : addr_q[AW-1:0];
  assign mem_wd = cmd_i.clear ? 8'd0 : copy_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      store_rd_q <= store_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        list_q[i] <= StepIdle;
      end
      ptr_q      <= '0;
      alo_q      <= '0;
      ahi_q      <= '0;
      end_q      <= '0;
      off_q      <= '0;
      addr_q     <= '0;
      copy_idx_q <= '0;
      clock_q    <= '0;
      clr_idx_q  <= '0;
      src_q      <= SrcZero;
      for (int i = 0; i < ScratchBytes; i++) begin
        scratch_q[i] <= '0;
      end
    end else begin
      list_q     <= list_d;
      ptr_q      <= ptr_d;
      alo_q      <= alo_d;
      ahi_q      <= ahi_d;
      end_q      <= end_d;
      off_q      <= off_d;
      addr_q     <= addr_d;
      copy_idx_q <= copy_idx_d;
      clock_q    <= clock_d;
      src_q      <= src_d;
      if (cmd_i.clear) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (sp_we) begin
        scratch_q[off_q[ScratchIdxW-1:0]] <= write_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      clk_byte_q <= clk_byte;
    end
    if (cmd_i.capture) begin
      unique case (src_q)
        SrcStore: read_data_q <= store_rd_q;
        SrcClock: read_data_q <= clk_byte_q;
        default:  read_data_q <= 8'd0;
      endcase
    end
  end

  assign read_data_o       = read_data_q;
  assign stat_o.copy_start = copy_start;
  assign stat_o.copy_last  = (copy_idx_q == end_q);
  assign stat_o.clear_last = (clr_idx_q == AW'(STORE_BYTES - 1));

endmodule

`default_nettype wire

// File: rtl/core/srnce_ctrl.sv
`default_nettype none

module srnce_ctrl import srnce_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic [1:0] CtlClear  = 2'd0;
  localparam logic [1:0] CtlIdle   = 2'd1;
  localparam logic [1:0] CtlCopy   = 2'd2;
  localparam logic [1:0] CtlResult = 2'd3;

  logic [1:0] state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == CtlIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      CtlClear: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = CtlIdle;
        end
      end
      CtlIdle: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = stat_i.copy_start ? CtlCopy : CtlResult;
        end
      end
      CtlCopy: begin
        cmd_o.copy = 1'b1;
        if (stat_i.copy_last) begin
          state_d = CtlResult;
        end
      end
      CtlResult: begin
        // The result moves into the output register once it is empty or draining.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CtlIdle;
        end
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtlClear) |-> !in_ready_o)
    else $error("transfer accepted during the clearing pass");

  a_capture_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured result not presented");

  a_copy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtlCopy && stat_i.copy_last) |=> (state_q == CtlResult))
    else $error("copy did not finish into the result state");

  a_plain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !stat_i.copy_start) |=> (state_q == CtlResult))
    else $error("plain step did not go to the result state");
`endif

endmodule

`default_nettype wire

// File: rtl/core/serial_rtc_nvram_command_engine_core.sv
// Each input transfer yields one result transfer. Most events take one sequencer step,
// then a load of the output register once it is empty or draining. A copy scratchpad
// start adds a copy of end offset + 1 bytes (up to 32), one byte per cycle, in between.
// After reset the store is cleared one byte a cycle; no input is accepted until the
// clearing pass ends. Other state resets asynchronously, but not the read data registers.
`default_nettype none

module serial_rtc_nvram_command_engine_core import srnce_pkg::*; #(
  parameter int unsigned STORE_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] kind_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  srnce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srnce_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .write_data_i (write_data_i),
    .stat_o       (stat),
    .read_data_o  (read_data_o)
  );

endmodule

`default_nettype wire

// File: bench/serial_rtc_nvram_command_engine_core_test.sv
module serial_rtc_nvram_command_engine_core_test;
  import srnce_pkg::*;

  localparam int unsigned StoreBytes = 512;
  localparam int unsigned StoreIdxW = $clog2(StoreBytes);
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
  } event_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] kind = 3'd0;
  logic [7:0] write_data = 8'd0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] read_data;

  serial_rtc_nvram_command_engine_core #(
    .STORE_BYTES(StoreBytes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .write_data_i(write_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_data_o (read_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Events waiting to be offered, and read bytes predicted for accepted events.
  event_item_t event_q[$];
  logic [7:0]  read_data_expect_q[$];
  event_item_t drv_item;
  int          items_queued = 0;
  int          items_accepted = 0;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          in_taken = 1'b0;
  bit          hold_phase = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_count = 0;

  // Predicted engine state.
  step_e      seq_steps[8];
  logic [2:0] seq_ptr;
  logic [15:0] mem_addr;
  logic [5:0] sp_offset;
  logic [4:0] copy_last;
  logic [7:0] addr_lo;
  logic [7:0] addr_hi;
  logic [7:0] sp_bytes[ScratchBytes];
  logic [39:0] rtc_count;
  logic [7:0] nv_bytes[StoreBytes];

  function automatic logic [7:0] bus_read();
    logic [39:0] shifted;
    if (mem_addr < StoreBytes && mem_addr < AddrStoreEnd) begin
      return nv_bytes[mem_addr[StoreIdxW-1:0]];
    end
    if (mem_addr >= AddrClockFirst && mem_addr <= AddrClockLast) begin
      shifted = rtc_count >> (8 * (mem_addr - AddrClockFirst));
      return shifted[7:0];
    end
    return 8'd0;
  endfunction

  function automatic void bus_write(logic [7:0] v);
    int idx;
    if (mem_addr < StoreBytes && mem_addr < AddrStoreEnd) begin
      nv_bytes[mem_addr[StoreIdxW-1:0]] = v;
    end else if (mem_addr >= AddrClockFirst && mem_addr <= AddrClockLast) begin
      idx = int'(mem_addr - AddrClockFirst);
      rtc_count[8*idx +: 8] = v;
    end
  endfunction

  function automatic void load_steps(step_e last_step, bit with_ofs);
    seq_steps[0] = StepAddrLo;
    seq_steps[1] = StepAddrHi;
    if (with_ofs) begin
      seq_steps[2] = StepEndOfs;
      seq_steps[3] = StepStart;
      seq_steps[4] = last_step;
    end else begin
      seq_steps[2] = StepStart;
      seq_steps[3] = last_step;
    end
    seq_ptr = 3'd0;
  endfunction

  function automatic void start_step();
    step_e       nxt_step;
    logic [15:0] base;
    nxt_step = seq_steps[seq_ptr + 3'd1];
    base = {addr_hi, addr_lo};
    if (nxt_step == StepReadMem) begin
      mem_addr = base - 16'd1;
    end else if (nxt_step == StepWriteSp) begin
      mem_addr = base;
      sp_offset = {1'b0, base[4:0]};
    end else if (nxt_step == StepCopySp) begin
      mem_addr = base;
      for (int i = 0; i <= copy_last; i++) begin
        bus_write(sp_bytes[i]);
        mem_addr = mem_addr + 16'd1;
      end
    end
    seq_ptr = seq_ptr + 3'd1;
  endfunction

  function automatic void write_byte(logic [7:0] d);
    case (seq_steps[seq_ptr])
      StepIdle: begin
        if (d == CmdSkipRom) begin
          seq_steps[0] = StepCommand;
          seq_ptr = 3'd0;
        end
      end
      StepCommand: begin
        if (d == CmdWriteSp) load_steps(StepWriteSp, 1'b0);
        else if (d == CmdCopySp) load_steps(StepCopySp, 1'b1);
        else if (d == CmdReadMem) load_steps(StepReadMem, 1'b0);
      end
      StepAddrLo: begin
        addr_lo = d;
        seq_ptr = seq_ptr + 3'd1;
      end
      StepAddrHi: begin
        addr_hi = d;
        seq_ptr = seq_ptr + 3'd1;
      end
      StepEndOfs: begin
        copy_last = (d > ScratchLast) ? ScratchLast : d[4:0];
        seq_ptr = seq_ptr + 3'd1;
      end
      StepWriteSp: begin
        if (sp_offset < ScratchFull) begin
          sp_bytes[sp_offset[4:0]] = d;
          sp_offset = sp_offset + 6'd1;
        end
      end
      default: ;
    endcase
    if (seq_steps[seq_ptr] == StepStart) start_step();
  endfunction

  function automatic logic [7:0] predict_read_data(logic [2:0] k, logic [7:0] d);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      KindOneWireReset: begin
        seq_steps[0] = StepIdle;
        seq_ptr = 3'd0;
      end
      KindThreeWireReset: begin
        seq_steps[0] = StepCommand;
        seq_ptr = 3'd0;
      end
      KindWrite: write_byte(d);
      KindRead: if (seq_steps[seq_ptr] == StepReadMem) r = bus_read();
      KindClockPulse: if (seq_steps[seq_ptr] == StepReadMem) mem_addr = mem_addr + 16'd1;
      KindTick: rtc_count = rtc_count + 40'd1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_item(logic [2:0] k, logic [7:0] d);
    event_q.push_back('{kind: k, data: d});
    items_queued++;
  endtask

  function automatic logic [15:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 63));
    if (r < 65) return 16'($urandom_range(16'h01E0, 16'h01FF));
    if (r < 80) return 16'($urandom_range(16'h01FC, 16'h020A));
    if (r < 88) return 16'($urandom_range(16'hFFF8, 16'hFFFF));
    return 16'($urandom);
  endfunction

  // One command sequence with random content; a few are noise or cut short.
  task automatic add_random_sequence();
    int          sel;
    int          cmd;
    int          n;
    int          op;
    logic [15:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      push_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      return;
    end
    if (sel >= 12) begin
      if ($urandom_range(0, 1) == 1) begin
        push_item(KindOneWireReset, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) push_item(KindWrite, 8'($urandom_range(0, 255)));
        push_item(KindWrite, CmdSkipRom);
      end else begin
        push_item(KindThreeWireReset, 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 19) == 0) push_item(KindWrite, 8'($urandom_range(0, 255)));
    cmd = $urandom_range(0, 2);
    push_item(KindWrite, (cmd == 0) ? CmdWriteSp : (cmd == 1) ? CmdCopySp : CmdReadMem);
    a = pick_address();
    push_item(KindWrite, a[7:0]);
    if ($urandom_range(0, 19) == 0) return;
    push_item(KindWrite, a[15:8]);
    case (cmd)
      0: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) begin
            push_item(3'($urandom_range(3, 5)), 8'($urandom_range(0, 255)));
          end else begin
            push_item(KindWrite, 8'($urandom_range(0, 255)));
          end
        end
      end
      1: begin
        push_item(KindWrite, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                           8'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0) push_item(KindWrite, 8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          op = $urandom_range(0, 9);
          if (op < 5) push_item(KindRead, 8'($urandom_range(0, 255)));
          else if (op < 9) push_item(KindClockPulse, 8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 1) == 1) push_item(KindTick, 8'($urandom_range(0, 255)));
          else push_item(KindWrite, 8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic run_phase(int s_pct, int r_pct, int n_items);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = items_queued + n_items;
    while (items_queued < target) add_random_sequence();
    while (event_q.size() != 0) @(posedge clk_i);
  endtask

  // Sender: a new event is offered only once the previous one has been transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = event_q.pop_front();
        in_valid <= 1'b1;
        kind <= drv_item.kind;
        write_data <= drv_item.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off at the start of the last phase.
  always @(negedge clk_i) begin
    if (hold_phase && !hold_done) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count == HoldCycles) hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] exp_byte;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (read_data_expect_q.size() == 0) begin
          $error("unexpected result transfer: read_data %0h", read_data);
          error_count++;
        end else begin
          exp_byte = read_data_expect_q.pop_front();
          if (read_data !== exp_byte) begin
            $error("read_data mismatch: expected %0h, actual %0h", exp_byte, read_data);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        items_accepted++;
        read_data_expect_q.push_back(predict_read_data(kind, write_data));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("serial_rtc_nvram_command_engine_core_test NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) seq_steps[i] = StepIdle;
    seq_ptr = 3'd0;
    mem_addr = 16'd0;
    sp_offset = 6'd0;
    copy_last = 5'd0;
    addr_lo = 8'd0;
    addr_hi = 8'd0;
    for (int i = 0; i < ScratchBytes; i++) sp_bytes[i] = 8'd0;
    rtc_count = 40'd0;
    for (int i = 0; i < StoreBytes; i++) nv_bytes[i] = 8'd0;

    // Reads and pulses outside a read, and the two unused kinds.
    push_item(KindRead, 8'hA5);
    push_item(KindClockPulse, 8'h5A);
    push_item(3'd6, 8'hFF);
    push_item(3'd7, 8'h00);
    // Unknown ROM and memory commands, then a scratchpad load of all ones.
    push_item(KindOneWireReset, 8'hFF);
    push_item(KindWrite, 8'h00);
    push_item(KindWrite, CmdSkipRom);
    push_item(KindWrite, 8'h12);
    push_item(KindWrite, CmdWriteSp);
    push_item(KindWrite, 8'h00);
    push_item(KindWrite, 8'h00);
    repeat (5) push_item(KindWrite, 8'hFF);
    // Copy into the counter with an oversized end offset, running into the hole.
    push_item(KindThreeWireReset, 8'h00);
    push_item(KindWrite, CmdCopySp);
    push_item(KindWrite, 8'h02);
    push_item(KindWrite, 8'h02);
    push_item(KindWrite, 8'hFF);
    push_item(KindWrite, 8'h77);
    // The counter now holds all ones, so this tick wraps it.
    push_item(KindTick, 8'h00);
    push_item(KindThreeWireReset, 8'h00);
    push_item(KindWrite, CmdReadMem);
    push_item(KindWrite, 8'h02);
    push_item(KindWrite, 8'h02);
    push_item(KindRead, 8'h00);
    push_item(KindClockPulse, 8'h00);
    push_item(KindRead, 8'h00);
    push_item(KindWrite, 8'h3C);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_phase(21, 70, 640);
    run_phase(70, 21, 640);
    hold_phase = 1'b1;
    run_phase(0, 0, 640);

    while (items_accepted != items_queued || read_data_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (read_data_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", read_data_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("serial_rtc_nvram_command_engine_core_test OK");
    end else begin
      $display("serial_rtc_nvram_command_engine_core_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/srnce_pkg.sv
rtl/core/srnce_dp.sv
rtl/core/srnce_ctrl.sv
rtl/core/serial_rtc_nvram_command_engine_core.sv
bench/serial_rtc_nvram_command_engine_core_test.sv
